FILE: rtl/core/truth_value_combiner_unit_macros.svh
// Assertion macros for the truth value combiner unit.
// Included by files that assert; depends on nothing.
`ifndef TRUTH_VALUE_COMBINER_UNIT_MACROS_SVH
`define TRUTH_VALUE_COMBINER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TVC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvc assertion failed");
`define TVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvc assertion failed");
`else
`define TVC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TVC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/tvc_pkg.sv
// Shared types, constants and helpers of the truth value combiner.
// Used by tvc_front, tvc_div and truth_value_combiner_unit.
package tvc_pkg;

   localparam int FRACTION_BITS = 15;
   localparam int Q_WIDTH       = 16;
   localparam int COUNT_WIDTH   = 32;
   localparam int P_WIDTH       = 2 * Q_WIDTH;
   localparam int D_WIDTH       = P_WIDTH;
   localparam int N_WIDTH       = D_WIDTH + Q_WIDTH;
   localparam int DIV_STAGES    = Q_WIDTH;
   localparam int Y_WIDTH       = 19;
   localparam int RECIP_SHIFT   = 22;
   localparam logic [Y_WIDTH-1:0] RECIP_MULT = 19'd419431;

   localparam logic [Q_WIDTH-1:0] FX_ONE  = Q_WIDTH'(1) << FRACTION_BITS;
   localparam logic [Q_WIDTH-1:0] FX_HALF = Q_WIDTH'(1) << (FRACTION_BITS - 1);

   typedef enum logic [2:0] {
      OP_DEDUCTION = 3'd0,
      OP_INDUCTION = 3'd1,
      OP_ABDUCTION = 3'd2,
      OP_REVISION  = 3'd3,
      OP_AND       = 3'd4,
      OP_OR        = 3'd5,
      OP_NOT       = 3'd6
   } opcode_type;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [Q_WIDTH-1:0]     strength_a;
      logic [Q_WIDTH-1:0]     confidence_a;
      logic [COUNT_WIDTH-1:0] count_a;
      logic [Q_WIDTH-1:0]     strength_b;
      logic [Q_WIDTH-1:0]     confidence_b;
      logic [COUNT_WIDTH-1:0] count_b;
   } req_type;

   typedef struct packed {
      logic [Q_WIDTH-1:0]     strength_out;
      logic [Q_WIDTH-1:0]     confidence_out;
      logic [COUNT_WIDTH-1:0] count_out;
      logic                   count_saturated;
      logic                   undefined_ratio;
   } rsp_type;

   typedef struct packed {
      logic [Q_WIDTH-1:0]     strength;
      logic [Q_WIDTH-1:0]     confidence;
      logic [COUNT_WIDTH-1:0] count;
      logic                   saturated;
      logic                   undefined;
      logic                   sel_div_s;
      logic                   sel_div_c;
   } side_type;

   typedef struct packed {
      logic [N_WIDTH-1:0] num;
      logic [D_WIDTH-1:0] den;
   } div_op_type;

   function automatic logic [Q_WIDTH-1:0] clamp_q(input logic [Q_WIDTH-1:0] v);
      return (v > FX_ONE) ? FX_ONE : v;
   endfunction

endpackage

FILE: rtl/core/tvc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tvc_pkg.
module tvc_div (
   input  logic                        clock,
   input  logic [tvc_pkg::N_WIDTH-1:0] div_num,
   input  logic [tvc_pkg::D_WIDTH-1:0] div_den,
   output logic [tvc_pkg::Q_WIDTH-1:0] div_quo
);
   localparam int QW = tvc_pkg::Q_WIDTH;
   localparam int DW = tvc_pkg::D_WIDTH;
   localparam int NW = tvc_pkg::N_WIDTH;
   localparam int ST = tvc_pkg::DIV_STAGES;

   logic [DW-1:0] rem_ff [ST];
   logic [DW-1:0] den_ff [ST];
   logic [QW-1:0] low_ff [ST];
   logic [QW-1:0] quo_ff [ST];

   for (genvar k = 0; k < ST; k++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] quo_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      if (k == 0) begin : g_first
         assign rem_src = div_num[NW-1:QW];
         assign den_src = div_den;
         assign low_src = div_num[QW-1:0];
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end
      assign trial = {rem_src, low_src[QW-1]};
      assign diff  = trial - {1'b0, den_src};
      always_ff @(posedge clock) begin
         if (trial >= {1'b0, den_src}) begin
            rem_ff[k] <= diff[DW-1:0];
            quo_ff[k] <= {quo_src[QW-2:0], 1'b1};
         end else begin
            rem_ff[k] <= trial[DW-1:0];
            quo_ff[k] <= {quo_src[QW-2:0], 1'b0};
         end
         den_ff[k] <= den_src;
         low_ff[k] <= {low_src[QW-2:0], 1'b0};
      end
   end

   assign div_quo = quo_ff[ST-1];
endmodule

FILE: rtl/core/tvc_front.sv
// Front stages: clamp, products, per-opcode results and divider operands.
// Depends on tvc_pkg.
module tvc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_valid,
   input  tvc_pkg::req_type     beat,
   output logic                 front_valid,
   output tvc_pkg::side_type    front_side,
   output tvc_pkg::div_op_type  front_div_s,
   output tvc_pkg::div_op_type  front_div_c
);
   localparam int QW = tvc_pkg::Q_WIDTH;
   localparam int PW = tvc_pkg::P_WIDTH;
   localparam int CW = tvc_pkg::COUNT_WIDTH;
   localparam int NW = tvc_pkg::N_WIDTH;
   localparam int DW = tvc_pkg::D_WIDTH;
   localparam int YW = tvc_pkg::Y_WIDTH;
   localparam int FB = tvc_pkg::FRACTION_BITS;

   // stage 1
   logic          v1_ff;
   logic [2:0]    op1_ff;
   logic [QW-1:0] sa1_ff, ca1_ff, sb1_ff, cb1_ff;
   logic [CW-1:0] na1_ff, nb1_ff;
   // stage 2
   logic          v2_ff;
   logic [2:0]    op2_ff;
   logic [QW-1:0] sa2_ff, ca2_ff;
   logic [PW-1:0] pss2_ff, pcc2_ff, pnn2_ff, psc2_ff, qsc2_ff;
   logic [QW:0]   w2_ff, sab2_ff;
   logic [CW:0]   sum2_ff;
   logic [CW-1:0] na2_ff;
   // stage 3
   logic                v3_ff;
   logic [2:0]          op3_ff;
   logic [YW-1:0]       sy3_ff, cy3_ff;
   tvc_pkg::side_type   side3_ff, side3_in;
   tvc_pkg::div_op_type divs3_ff, divs3_in, divc3_ff, divc3_in;
   // stage 4
   logic                v4_ff;
   tvc_pkg::side_type   side4_ff, side4_in;
   tvc_pkg::div_op_type divs4_ff, divc4_ff;

   logic [QW-1:0]   ms3, mc3;
   logic [PW-1:0]   den3, rnum3;
   logic [QW:0]     or3;
   logic [2*YW-1:0] sprod4, cprod4;

   always_comb begin
      ms3   = QW'(pss2_ff >> FB);
      mc3   = QW'(pcc2_ff >> FB);
      den3  = pss2_ff + pnn2_ff;
      rnum3 = psc2_ff + qsc2_ff;
      or3   = sab2_ff - {1'b0, ms3};
      side3_in = '0;
      divs3_in.num = NW'(den3) << FB;
      divs3_in.den = (den3 == '0) ? DW'(1) : den3;
      divc3_in.num = NW'(w2_ff) << FB;
      divc3_in.den = DW'(w2_ff) + DW'(tvc_pkg::FX_ONE);
      unique case (op2_ff)
         tvc_pkg::OP_DEDUCTION, tvc_pkg::OP_AND: begin
            side3_in.strength   = ms3;
            side3_in.confidence = mc3;
         end
         tvc_pkg::OP_INDUCTION: begin
            side3_in.strength  = tvc_pkg::FX_HALF;
            side3_in.undefined = (den3 == '0);
            side3_in.sel_div_s = (den3 != '0);
            divs3_in.num = NW'(pss2_ff) << FB;
         end
         tvc_pkg::OP_ABDUCTION: begin
         end
         tvc_pkg::OP_REVISION: begin
            side3_in.strength  = tvc_pkg::FX_HALF;
            side3_in.sel_div_s = (w2_ff != '0);
            side3_in.sel_div_c = (w2_ff != '0);
            divs3_in.num = NW'(rnum3);
            divs3_in.den = (w2_ff == '0) ? DW'(1) : DW'(w2_ff);
         end
         tvc_pkg::OP_OR: begin
            side3_in.strength   = (or3 > {1'b0, tvc_pkg::FX_ONE}) ?
                                  tvc_pkg::FX_ONE : or3[QW-1:0];
            side3_in.confidence = w2_ff[QW:1];
         end
         tvc_pkg::OP_NOT: begin
            side3_in.strength   = tvc_pkg::FX_ONE - sa2_ff;
            side3_in.confidence = ca2_ff;
         end
         default: begin
         end
      endcase
      unique case (op2_ff)
         tvc_pkg::OP_INDUCTION, tvc_pkg::OP_NOT: begin
            side3_in.count = na2_ff;
         end
         tvc_pkg::OP_DEDUCTION, tvc_pkg::OP_AND, tvc_pkg::OP_ABDUCTION,
         tvc_pkg::OP_REVISION, tvc_pkg::OP_OR: begin
            side3_in.saturated = sum2_ff[CW];
            side3_in.count     = sum2_ff[CW] ? '1 : sum2_ff[CW-1:0];
         end
         default: begin
         end
      endcase
   end

   // divide by ten through a reciprocal multiply
   always_comb begin
      sprod4   = sy3_ff * tvc_pkg::RECIP_MULT;
      cprod4   = cy3_ff * tvc_pkg::RECIP_MULT;
      side4_in = side3_ff;
      if (op3_ff == tvc_pkg::OP_ABDUCTION) begin
         side4_in.strength   = QW'(sprod4 >> tvc_pkg::RECIP_SHIFT);
         side4_in.confidence = QW'(cprod4 >> tvc_pkg::RECIP_SHIFT);
      end else if (op3_ff == tvc_pkg::OP_INDUCTION) begin
         side4_in.confidence = QW'(cprod4 >> tvc_pkg::RECIP_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= beat_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      op1_ff  <= beat.opcode;
      sa1_ff  <= tvc_pkg::clamp_q(beat.strength_a);
      ca1_ff  <= tvc_pkg::clamp_q(beat.confidence_a);
      sb1_ff  <= tvc_pkg::clamp_q(beat.strength_b);
      cb1_ff  <= tvc_pkg::clamp_q(beat.confidence_b);
      na1_ff  <= beat.count_a;
      nb1_ff  <= beat.count_b;
      op2_ff  <= op1_ff;
      sa2_ff  <= sa1_ff;
      ca2_ff  <= ca1_ff;
      pss2_ff <= sa1_ff * sb1_ff;
      pcc2_ff <= ca1_ff * cb1_ff;
      pnn2_ff <= (tvc_pkg::FX_ONE - sa1_ff) * (tvc_pkg::FX_ONE - sb1_ff);
      psc2_ff <= sa1_ff * ca1_ff;
      qsc2_ff <= sb1_ff * cb1_ff;
      w2_ff   <= {1'b0, ca1_ff} + {1'b0, cb1_ff};
      sab2_ff <= {1'b0, sa1_ff} + {1'b0, sb1_ff};
      sum2_ff <= {1'b0, na1_ff} + {1'b0, nb1_ff};
      na2_ff  <= na1_ff;
      op3_ff   <= op2_ff;
      sy3_ff   <= YW'(ms3) << 3;
      cy3_ff   <= (op2_ff == tvc_pkg::OP_INDUCTION) ?
                  (YW'(mc3) << 3) + YW'(mc3) : (YW'(mc3) << 3) - YW'(mc3);
      side3_ff <= side3_in;
      divs3_ff <= divs3_in;
      divc3_ff <= divc3_in;
      side4_ff <= side4_in;
      divs4_ff <= divs3_ff;
      divc4_ff <= divc3_ff;
   end

   assign front_valid = v4_ff;
   assign front_side  = side4_ff;
   assign front_div_s = divs4_ff;
   assign front_div_c = divc4_ff;
endmodule

FILE: rtl/core/truth_value_combiner_unit.sv
// Throughput: one item per cycle; busy stays low, the 16-stage divider is fully pipelined.
// Reset clears all valid bits; no result follows until a new beat is accepted.
// Results appear for one cycle under rsp_strobe; the receiver cannot stall.
// Top level of the truth value combiner: front stages, two dividers, output register.
// Depends on tvc_pkg, tvc_front, tvc_div and the macros header.
`include "truth_value_combiner_unit_macros.svh"
module truth_value_combiner_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tvc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tvc_pkg::rsp_type rsp_data
);
   localparam int ST = tvc_pkg::DIV_STAGES;
   localparam int QW = tvc_pkg::Q_WIDTH;

   logic                front_valid;
   tvc_pkg::side_type   front_side;
   tvc_pkg::div_op_type front_div_s, front_div_c;
   logic [QW-1:0]       quo_s, quo_c;

   logic              side_valid_ff [ST];
   tvc_pkg::side_type side_ff [ST];
   logic              strobe_ff;
   tvc_pkg::rsp_type  rsp_ff, rsp_in;

   assign busy = 1'b0;

   tvc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (start && !busy),
      .beat        (req_data),
      .front_valid (front_valid),
      .front_side  (front_side),
      .front_div_s (front_div_s),
      .front_div_c (front_div_c)
   );

   tvc_div u_div_s (
      .clock   (clock),
      .div_num (front_div_s.num),
      .div_den (front_div_s.den),
      .div_quo (quo_s)
   );

   tvc_div u_div_c (
      .clock   (clock),
      .div_num (front_div_c.num),
      .div_den (front_div_c.den),
      .div_quo (quo_c)
   );

   always_comb begin
      rsp_in.strength_out    = side_ff[ST-1].sel_div_s ? quo_s : side_ff[ST-1].strength;
      rsp_in.confidence_out  = side_ff[ST-1].sel_div_c ? quo_c : side_ff[ST-1].confidence;
      rsp_in.count_out       = side_ff[ST-1].count;
      rsp_in.count_saturated = side_ff[ST-1].saturated;
      rsp_in.undefined_ratio = side_ff[ST-1].undefined;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ST; k++) begin
            side_valid_ff[k] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         side_valid_ff[0] <= front_valid;
         for (int k = 1; k < ST; k++) begin
            side_valid_ff[k] <= side_valid_ff[k-1];
         end
         strobe_ff <= side_valid_ff[ST-1];
      end
      side_ff[0] <= front_side;
      for (int k = 1; k < ST; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `TVC_ASSERT_IMPLIES(a_strobe_from_beat, clock, reset, rsp_strobe,
      $past(start && !busy && !reset, 21))
   `TVC_ASSERT_NEXT(a_tail_to_strobe, clock, reset, side_valid_ff[ST-1], rsp_strobe)
   `TVC_ASSERT_IMPLIES(a_undef_half, clock, reset, rsp_strobe && rsp_data.undefined_ratio,
      rsp_data.strength_out == tvc_pkg::FX_HALF && !rsp_data.count_saturated)
   `TVC_ASSERT_IMPLIES(a_sat_max, clock, reset, rsp_strobe && rsp_data.count_saturated,
      rsp_data.count_out == '1)
endmodule

FILE: sim/tb_truth_value_combiner_unit.sv
// Testbench for truth_value_combiner_unit: drives opcode/truth-value beats and
// checks every result against a built-in predictor. Depends on tvc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_truth_value_combiner_unit;

   localparam int LATENCY = 21;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tvc_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   tvc_pkg::rsp_type rsp_data;

   tvc_pkg::rsp_type expected_truth_q[$];
   int      error_count = 0;
   int      beats_sent = 0;
   int      results_seen = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   truth_value_combiner_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL truth_value_combiner_unit");
         $finish;
      end
   end

   function automatic logic [63:0] clamp_fx(input logic [15:0] v);
      return (v > 16'd32768) ? 64'd32768 : {48'd0, v};
   endfunction

   function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
      return (x * y) >> 15;
   endfunction

   function automatic tvc_pkg::rsp_type combine_truth(input tvc_pkg::req_type r);
      tvc_pkg::rsp_type t;
      logic [63:0] sa, ca, sb, cb, na, nb, num, den, w, sum;
      sa = clamp_fx(r.strength_a);
      ca = clamp_fx(r.confidence_a);
      sb = clamp_fx(r.strength_b);
      cb = clamp_fx(r.confidence_b);
      na = {32'd0, r.count_a};
      nb = {32'd0, r.count_b};
      t = '0;
      sum = na + nb;
      if (sum > 64'hFFFF_FFFF) begin
         t.count_out = 32'hFFFF_FFFF;
         t.count_saturated = 1'b1;
      end else begin
         t.count_out = sum[31:0];
      end
      case (r.opcode)
         tvc_pkg::OP_DEDUCTION, tvc_pkg::OP_AND: begin
            t.strength_out = 16'(fx_mul(sa, sb));
            t.confidence_out = 16'(fx_mul(ca, cb));
         end
         tvc_pkg::OP_INDUCTION: begin
            num = sa * sb;
            den = num + (64'd32768 - sa) * (64'd32768 - sb);
            if (den == 0) begin
               t.strength_out = 16'd16384;
               t.undefined_ratio = 1'b1;
            end else begin
               t.strength_out = 16'((num << 15) / den);
            end
            t.confidence_out = 16'(fx_mul(ca, cb) * 9 / 10);
            t.count_out = r.count_a;
            t.count_saturated = 1'b0;
         end
         tvc_pkg::OP_ABDUCTION: begin
            t.strength_out = 16'(fx_mul(sa, sb) * 8 / 10);
            t.confidence_out = 16'(fx_mul(ca, cb) * 7 / 10);
         end
         tvc_pkg::OP_REVISION: begin
            w = ca + cb;
            if (w > 0) begin
               t.strength_out = 16'((sa * ca + sb * cb) / w);
               t.confidence_out = 16'((w << 15) / (w + 64'd32768));
            end else begin
               t.strength_out = 16'd16384;
               t.confidence_out = 16'd0;
            end
         end
         tvc_pkg::OP_OR: begin
            num = sa + sb - fx_mul(sa, sb);
            t.strength_out = (num > 64'd32768) ? 16'd32768 : num[15:0];
            t.confidence_out = 16'((ca + cb) >> 1);
         end
         tvc_pkg::OP_NOT: begin
            t.strength_out = 16'(64'd32768 - sa);
            t.confidence_out = 16'(ca);
            t.count_out = r.count_a;
            t.count_saturated = 1'b0;
         end
         default: t = '0;
      endcase
      return t;
   endfunction

   always @(posedge clock) begin
      tvc_pkg::rsp_type exp_t;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_truth_q.size() == 0) begin
            $error("result with no beat pending: %h", rsp_data);
            error_count++;
         end else begin
            exp_t = expected_truth_q.pop_front();
            if (rsp_data.strength_out !== exp_t.strength_out) begin
               $error("strength_out exp %0d got %0d", exp_t.strength_out,
                      rsp_data.strength_out);
               error_count++;
            end
            if (rsp_data.confidence_out !== exp_t.confidence_out) begin
               $error("confidence_out exp %0d got %0d", exp_t.confidence_out,
                      rsp_data.confidence_out);
               error_count++;
            end
            if (rsp_data.count_out !== exp_t.count_out) begin
               $error("count_out exp %0d got %0d", exp_t.count_out, rsp_data.count_out);
               error_count++;
            end
            if (rsp_data.count_saturated !== exp_t.count_saturated) begin
               $error("count_saturated exp %0b got %0b", exp_t.count_saturated,
                      rsp_data.count_saturated);
               error_count++;
            end
            if (rsp_data.undefined_ratio !== exp_t.undefined_ratio) begin
               $error("undefined_ratio exp %0b got %0b", exp_t.undefined_ratio,
                      rsp_data.undefined_ratio);
               error_count++;
            end
         end
      end
   end

   // send one beat; start stays high into the next call when no gap is drawn
   task automatic send_beat(input tvc_pkg::req_type r);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_truth_q.push_back(combine_truth(r));
      beats_sent++;
   endtask

   function automatic logic [15:0] rand_fx();
      case ($urandom_range(9, 0))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom_range(65535, 32769));
         3: return 16'($urandom_range(65535, 0));
         default: return 16'($urandom_range(32768, 0));
      endcase
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(5, 0))
         0: return 32'hFFFF_FFFF - 32'($urandom_range(3, 0));
         1: return 32'($urandom_range(100, 0));
         2: return {1'b1, 31'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   function automatic tvc_pkg::req_type make_item(input logic [2:0] op,
                                         input logic [15:0] sa, input logic [15:0] ca,
                                         input logic [31:0] na, input logic [15:0] sb,
                                         input logic [15:0] cb, input logic [31:0] nb);
      tvc_pkg::req_type r;
      r.opcode = op;
      r.strength_a = sa;
      r.confidence_a = ca;
      r.count_a = na;
      r.strength_b = sb;
      r.confidence_b = cb;
      r.count_b = nb;
      return r;
   endfunction

   task automatic test_directed();
      logic [2:0] op;
      for (int i = 0; i < 8; i++) begin
         op = 3'(i);
         send_beat(make_item(op, 16'd32768, 16'd32768, 32'hFFFF_FFFF,
                             16'd20000, 16'd9000, 32'd5));
         send_beat(make_item(op, 16'hFFFF, 16'h0000, 32'd0,
                             16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      end
      // induction zero over zero both ways
      send_beat(make_item(tvc_pkg::OP_INDUCTION, 16'd0, 16'd100, 32'd7,
                          16'd32768, 16'd200, 32'd1));
      send_beat(make_item(tvc_pkg::OP_INDUCTION, 16'hFFFF, 16'd100, 32'd7,
                          16'd0, 16'd200, 32'd1));
      // revision without weight
      send_beat(make_item(tvc_pkg::OP_REVISION, 16'd1234, 16'd0, 32'd3,
                          16'd777, 16'd0, 32'd4));
      send_beat(make_item(tvc_pkg::OP_OR, 16'd32768, 16'd32768, 32'h8000_0000,
                          16'd32768, 16'd32768, 32'h8000_0000));
      send_beat(make_item(tvc_pkg::OP_DEDUCTION, 16'd0, 16'd0, 32'h7FFF_FFFF,
                          16'd0, 16'd0, 32'h8000_0000));
   endtask

   task automatic test_random(input int count, input int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         send_beat(make_item(3'($urandom_range(7, 0)), rand_fx(), rand_fx(), rand_count(),
                             rand_fx(), rand_fx(), rand_count()));
      end
      idle_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(380, 24);
      test_random(380, 67);
      test_random(390, 0);
      start <= 1'b0;
      while (expected_truth_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      $display("Sent %0d beats over all seven opcodes and the unused one; %0d results checked.",
               beats_sent, results_seen);
      if (error_count == 0) begin
         $display("PASS truth_value_combiner_unit");
      end else begin
         $display("FAIL truth_value_combiner_unit");
      end
      $finish;
   end
endmodule

FILE: truth_value_combiner_unit.f
+incdir+rtl/core
rtl/core/tvc_pkg.sv
rtl/core/tvc_div.sv
rtl/core/tvc_front.sv
rtl/core/truth_value_combiner_unit.sv
sim/tb_truth_value_combiner_unit.sv
